// ----- hdl/iou_box_class_matcher_unit_assert.svh -----
// Assertion macros for the box class matcher
`ifndef IOU_BOX_CLASS_MATCHER_UNIT_ASSERT_SVH
`define IOU_BOX_CLASS_MATCHER_UNIT_ASSERT_SVH

// Implication in the same cycle
`define IBCM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ibcm assertion failed");

// Implication in the next cycle
`define IBCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ibcm assertion failed");

`endif

// ----- hdl/ibcm_pkg.sv -----
package ibcm_pkg;

  localparam int unsigned DEPTH_DEF = 32;

  localparam logic [23:0] AREA_FLOOR_RST = 24'd100;
  localparam logic [15:0] OVERLAP_FLOOR_RST = 16'd13107;

  // func codes
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // result kinds
  localparam logic [1:0] HOW_OVERLAP = 2'd0;
  localparam logic [1:0] HOW_WINDOW  = 2'd1;
  localparam logic [1:0] HOW_DROP    = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_AREA_FLOOR    = 2'd0;
  localparam logic [1:0] CFG_OVERLAP_FLOOR = 2'd1;

  // reciprocal of ten for 19-bit numerators: floor(n*M >> 24)
  localparam logic [20:0] RECIP10 = 21'd1677722;

  // one stored detector box
  typedef struct packed {
    logic signed [15:0] x1;
    logic signed [15:0] x2;
    logic signed [15:0] y1;
    logic signed [15:0] y2;
    logic [1:0]         cls;
  } ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_MUL,
    ST_LD_WR,
    ST_Q_GEO,
    ST_Q_AREA,
    ST_Q_UNI,
    ST_Q_MUL,
    ST_Q_CMP,
    ST_Q_NEXT,
    ST_Q_THR
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7fff;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

// ----- hdl/ibcm_cell.sv -----
module ibcm_cell
  import ibcm_pkg::*;
(
  input  logic clk,
  input  logic shift_en,
  input  logic wr_en,
  input  ent_t nbr_i,
  input  ent_t wr_i,
  output ent_t ent_o
);

  ent_t ent_r;

  // take a new box or pass the neighbor's along the ring
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r <= wr_i;
    end else if (shift_en) begin
      ent_r <= nbr_i;
    end
  end

  assign ent_o = ent_r;

endmodule

// ----- hdl/ibcm_mul2.sv -----
module ibcm_mul2
  import ibcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a_a,
  input  logic [32:0] b_a,
  input  logic [31:0] a_b,
  input  logic [32:0] b_b,
  output logic [64:0] prod_a,
  output logic [64:0] prod_b,
  output logic        done
);

  logic [31:0] a_a_r, a_b_r;
  logic [32:0] b_a_r, b_b_r;
  logic [2:0]  cnt_r;
  logic        run_r, ppv_r, done_r;
  logic [32:0] pp_a_r, pp_b_r;
  logic [5:0]  sh_r;
  logic [64:0] acc_a_r, acc_b_r;
  logic [15:0] ha_a, ha_b;
  logic [16:0] hb_a, hb_b;

  // pick the halves for this partial product
  always_comb begin
    ha_a = cnt_r[1] ? a_a_r[31:16] : a_a_r[15:0];
    ha_b = cnt_r[1] ? a_b_r[31:16] : a_b_r[15:0];
    hb_a = cnt_r[0] ? b_a_r[32:16] : {1'b0, b_a_r[15:0]};
    hb_b = cnt_r[0] ? b_b_r[32:16] : {1'b0, b_b_r[15:0]};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      ppv_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        ppv_r <= 1'b0;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 3'd1;
        ppv_r <= (cnt_r < 3'd4);
        if (cnt_r == 3'd4) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // multiply one pair of halves, then accumulate it
  always_ff @(posedge clk) begin
    if (start) begin
      a_a_r   <= a_a;
      b_a_r   <= b_a;
      a_b_r   <= a_b;
      b_b_r   <= b_b;
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else if (run_r) begin
      pp_a_r <= 33'(ha_a * hb_a);
      pp_b_r <= 33'(ha_b * hb_b);
      sh_r   <= 6'd16 * (6'(cnt_r[0]) + 6'(cnt_r[1]));
      if (ppv_r) begin
        acc_a_r <= acc_a_r + (65'(pp_a_r) << sh_r);
        acc_b_r <= acc_b_r + (65'(pp_b_r) << sh_r);
      end
    end
  end

  assign prod_a = acc_a_r;
  assign prod_b = acc_b_r;
  assign done   = done_r;

endmodule

// ----- hdl/iou_box_class_matcher_unit.sv -----
// Channel   Ports                         Handshake
// input     start, busy, in_*             taken when start & !busy
// result    out_valid, out_*              one-cycle strobe, no back-pressure
// config    cfg_valid, cfg_ready, cfg_*   written when cfg_valid & cfg_ready
//
// Clear empties the table; load is an area multiply, then a ring write.
// A query walks DEPTH cells: it steps past each empty slot, runs geometry,
// areas and union for each stored box, and for an overlapping one also the
// four-step cross-multiply and compare, then the threshold test; the strobe follows.
// rst_n is synchronous; it empties the table and restores both registers.
// Results cannot be stalled; out_valid is high for exactly one cycle.
`include "iou_box_class_matcher_unit_assert.svh"

module iou_box_class_matcher_unit
  import ibcm_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_det_center_x,
  input  logic signed [15:0] in_det_center_y,
  input  logic [14:0]        in_det_width,
  input  logic [14:0]        in_det_height,
  input  logic [1:0]         in_det_class,
  input  logic signed [15:0] in_box_left,
  input  logic signed [15:0] in_box_right,
  input  logic signed [15:0] in_box_top,
  input  logic signed [15:0] in_box_bottom,
  input  logic signed [15:0] in_ground_x,
  input  logic signed [15:0] in_ground_y,
  output logic               out_valid,
  output logic               out_kept,
  output logic [1:0]         out_how,
  output logic [1:0]         out_class_out,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic               out_table_overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  state_t state_r, state_nxt;

  logic [23:0] area_floor_r;
  logic [15:0] overlap_floor_r;
  logic [CNT_W-1:0] count_r, j_r;
  logic ovf_r;

  // load word
  logic signed [15:0] cx_r, cy_r;
  logic [14:0] w_r, h_r;
  logic [1:0]  cls_r;
  logic        area_ok_r;
  logic [15:0] ww_r;

  // query word
  logic signed [15:0] ql_r, qr_r, qt_r, qb_r, gx_r, gy_r;
  logic signed [33:0] qarea_r;

  // per-entry evaluation
  logic [15:0] dx_r, dy_r, sw_r, sh_r;
  logic        cand_r;
  logic [31:0] inter_r, sarea_r;
  logic signed [35:0] uni_s;
  logic [32:0] uni_r;
  logic [31:0] best_i_r;
  logic [32:0] best_u_r;
  logic [1:0]  best_cls_r, ent_cls_r;
  logic        found_r;

  // output registers
  logic        out_valid_r, kept_r, ovf_out_r;
  logic [1:0]  how_r, cls_out_r;
  logic signed [15:0] ox_r, oy_r;

  // control strobes
  logic rot_en, wr_en, eng_start, thr_sel, accept, last_j;

  // ring of cells
  ent_t cell_q [DEPTH];
  ent_t wr_ent;
  ent_t head;

  // engine
  logic [31:0] eng_a_a, eng_a_b;
  logic [32:0] eng_b_a, eng_b_b;
  logic [64:0] prod_a, prod_b;
  logic        eng_done;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign head      = cell_q[0];
  assign last_j    = (j_r == CNT_W'(DEPTH - 1));

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      ibcm_cell u_cell (
        .clk      (clk),
        .shift_en (rot_en),
        .wr_en    (wr_en && (count_r == CNT_W'(gi))),
        .nbr_i    (cell_q[(gi + 1) % DEPTH]),
        .wr_i     (wr_ent),
        .ent_o    (cell_q[gi])
      );
    end
  endgenerate

  // build the widened box for storage
  always_comb begin
    logic signed [18:0] x1, y1;
    x1 = 19'(cx_r) - 19'($signed({1'b0, ww_r[15:1]}));
    y1 = 19'(cy_r) - 19'($signed({1'b0, h_r[14:1]}));
    wr_ent.x1  = sat16(x1);
    wr_ent.x2  = sat16(x1 + 19'($signed({1'b0, ww_r})));
    wr_ent.y1  = sat16(y1);
    wr_ent.y2  = sat16(y1 + 19'($signed({1'b0, h_r})));
    wr_ent.cls = (cls_r == 2'd3) ? 2'd0 : cls_r;
  end

  assign uni_s = 36'(qarea_r) + 36'($signed({1'b0, sarea_r}))
               - 36'($signed({1'b0, inter_r}));

  // engine operands: cross-multiply or threshold test
  always_comb begin
    if (thr_sel) begin
      eng_a_a = best_i_r;
      eng_b_a = 33'd65536;
      eng_a_b = {16'd0, overlap_floor_r};
      eng_b_b = best_u_r;
    end else begin
      eng_a_a = inter_r;
      eng_b_a = best_u_r;
      eng_a_b = best_i_r;
      eng_b_b = uni_s[32:0];
    end
  end

  ibcm_mul2 u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (eng_start),
    .a_a    (eng_a_a),
    .b_a    (eng_b_a),
    .a_b    (eng_a_b),
    .b_b    (eng_b_b),
    .prod_a (prod_a),
    .prod_b (prod_b),
    .done   (eng_done)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_LOAD) begin
            state_nxt = ST_LD_MUL;
          end else if (in_func == FUNC_QUERY) begin
            state_nxt = ST_Q_GEO;
          end
        end
      end
      ST_LD_MUL: state_nxt = ST_LD_WR;
      ST_LD_WR:  state_nxt = ST_IDLE;
      ST_Q_GEO: begin
        if (j_r < count_r) begin
          state_nxt = ST_Q_AREA;
        end else if (last_j) begin
          state_nxt = ST_Q_THR;
        end
      end
      ST_Q_AREA: state_nxt = ST_Q_UNI;
      ST_Q_UNI: begin
        if (cand_r && (uni_s > 36'sd0)) begin
          state_nxt = ST_Q_MUL;
        end else begin
          state_nxt = ST_Q_NEXT;
        end
      end
      ST_Q_MUL:  state_nxt = eng_done ? ST_Q_CMP : ST_Q_MUL;
      ST_Q_CMP:  state_nxt = ST_Q_NEXT;
      ST_Q_NEXT: state_nxt = last_j ? ST_Q_THR : ST_Q_GEO;
      ST_Q_THR:  state_nxt = eng_done ? ST_IDLE : ST_Q_THR;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    rot_en    = 1'b0;
    wr_en     = 1'b0;
    eng_start = 1'b0;
    thr_sel   = 1'b0;
    unique case (state_r)
      ST_LD_WR: wr_en = area_ok_r && (count_r != CNT_W'(DEPTH));
      ST_Q_GEO: begin
        if (!(j_r < count_r)) begin
          rot_en = 1'b1;
          if (last_j) begin
            eng_start = 1'b1;
            thr_sel   = 1'b1;
          end
        end
      end
      ST_Q_UNI: eng_start = cand_r && (uni_s > 36'sd0);
      ST_Q_NEXT: begin
        rot_en = 1'b1;
        if (last_j) begin
          eng_start = 1'b1;
          thr_sel   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      area_floor_r    <= AREA_FLOOR_RST;
      overlap_floor_r <= OVERLAP_FLOOR_RST;
      count_r         <= '0;
      ovf_r           <= 1'b0;
      j_r             <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == CFG_AREA_FLOOR) begin
          area_floor_r <= cfg_data;
        end else if (cfg_index == CFG_OVERLAP_FLOOR) begin
          overlap_floor_r <= cfg_data[15:0];
        end
      end
      if (accept && (in_func == FUNC_CLEAR)) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
      if (accept) begin
        j_r <= '0;
      end else if (rot_en) begin
        j_r <= j_r + CNT_W'(1);
      end
      if ((state_r == ST_LD_WR) && area_ok_r) begin
        if (count_r == CNT_W'(DEPTH)) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if ((state_r == ST_Q_THR) && eng_done) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    logic [18:0] num;
    num = 19'(in_det_width) * 19'd12 + 19'd5;
    if (accept) begin
      cx_r     <= in_det_center_x;
      cy_r     <= in_det_center_y;
      w_r      <= in_det_width;
      h_r      <= in_det_height;
      cls_r    <= in_det_class;
      ww_r     <= 16'((40'(num) * 40'(RECIP10)) >> 24);
      ql_r     <= in_box_left;
      qr_r     <= in_box_right;
      qt_r     <= in_box_top;
      qb_r     <= in_box_bottom;
      gx_r     <= in_ground_x;
      gy_r     <= in_ground_y;
      best_i_r <= '0;
      best_u_r <= 33'd1;
      best_cls_r <= '0;
      found_r  <= 1'b0;
    end
    // area test
    if (state_r == ST_LD_MUL) begin
      area_ok_r <= (32'(w_r * h_r) > {area_floor_r, 8'd0});
    end
    // query box area, taken once the edges are held
    if (state_r == ST_Q_GEO && j_r == '0) begin
      qarea_r <= 34'((18'(qr_r) - 18'(ql_r)) * (18'(qb_r) - 18'(qt_r)));
    end
    // overlap edges of the head cell
    if (state_r == ST_Q_GEO) begin
      logic signed [15:0] xl, xr, yt, yb;
      logic signed [16:0] dx, dy;
      xl = (ql_r > head.x1) ? ql_r : head.x1;
      xr = (qr_r < head.x2) ? qr_r : head.x2;
      yt = (qt_r > head.y1) ? qt_r : head.y1;
      yb = (qb_r < head.y2) ? qb_r : head.y2;
      dx = 17'(xr) - 17'(xl);
      dy = 17'(yb) - 17'(yt);
      cand_r    <= (dx > 17'sd0) && (dy > 17'sd0);
      dx_r      <= dx[15:0];
      dy_r      <= dy[15:0];
      sw_r      <= 16'(17'(head.x2) - 17'(head.x1));
      sh_r      <= 16'(17'(head.y2) - 17'(head.y1));
      ent_cls_r <= head.cls;
    end
    if (state_r == ST_Q_AREA) begin
      inter_r <= dx_r * dy_r;
      sarea_r <= sw_r * sh_r;
    end
    if (state_r == ST_Q_UNI) begin
      uni_r <= uni_s[32:0];
    end
    // keep a strictly better overlap
    if (state_r == ST_Q_CMP && (prod_a > prod_b)) begin
      best_i_r   <= inter_r;
      best_u_r   <= uni_r;
      best_cls_r <= ent_cls_r;
      found_r    <= 1'b1;
    end
    // decide the result
    if (state_r == ST_Q_THR && eng_done) begin
      logic signed [18:0] gx5, gy5;
      logic nearx;
      gx5 = 19'(gx_r) * 19'sd5;
      gy5 = 19'(gy_r) * 19'sd5;
      nearx = (gx5 > -19'sd512) && (gx5 < 19'sd512);
      ox_r      <= gx_r;
      oy_r      <= gy_r;
      ovf_out_r <= ovf_r;
      if (found_r && (prod_a > prod_b)) begin
        kept_r <= 1'b1; how_r <= HOW_OVERLAP; cls_out_r <= best_cls_r;
      end else if (nearx && (gy_r > -16'sd256) && (gy5 < -19'sd512)) begin
        kept_r <= 1'b1; how_r <= HOW_WINDOW; cls_out_r <= 2'd1;
      end else if (nearx && (gy_r < 16'sd256) && (gy5 > 19'sd512)) begin
        kept_r <= 1'b1; how_r <= HOW_WINDOW; cls_out_r <= 2'd2;
      end else begin
        kept_r <= 1'b0; how_r <= HOW_DROP; cls_out_r <= 2'd0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kept           = kept_r;
  assign out_how            = how_r;
  assign out_class_out      = cls_out_r;
  assign out_x              = ox_r;
  assign out_y              = oy_r;
  assign out_table_overflow = ovf_out_r;

  `IBCM_ASSERT_SAME(a_res_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE)
  `IBCM_ASSERT_NEXT(a_res_pulse, clk, rst_n, out_valid_r, !out_valid_r)
  `IBCM_ASSERT_SAME(a_count_max, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `IBCM_ASSERT_SAME(a_ring_home, clk, rst_n, state_r == ST_IDLE, j_r == '0 || j_r == CNT_W'(DEPTH))

endmodule

// ----- verif/iou_box_class_matcher_unit_tb.sv -----
module iou_box_class_matcher_unit_tb;
  import ibcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH = DEPTH_DEF;
  localparam int SETTLE = 500;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic               kept;
    logic [1:0]         how;
    logic [1:0]         cls;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic               ovf;
  } verdict_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_func;
  logic signed [15:0] in_det_center_x;
  logic signed [15:0] in_det_center_y;
  logic [14:0]        in_det_width;
  logic [14:0]        in_det_height;
  logic [1:0]         in_det_class;
  logic signed [15:0] in_box_left;
  logic signed [15:0] in_box_right;
  logic signed [15:0] in_box_top;
  logic signed [15:0] in_box_bottom;
  logic signed [15:0] in_ground_x;
  logic signed [15:0] in_ground_y;
  logic               out_valid;
  logic               out_kept;
  logic [1:0]         out_how;
  logic [1:0]         out_class_out;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic               out_table_overflow;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [23:0]        cfg_data;

  // shadow of the block's table and registers
  int          sh_x1[TBL_DEPTH];
  int          sh_x2[TBL_DEPTH];
  int          sh_y1[TBL_DEPTH];
  int          sh_y2[TBL_DEPTH];
  logic [1:0]  sh_cls[TBL_DEPTH];
  int          sh_count;
  logic        sh_ovf;
  logic [23:0] sh_area_floor;
  logic [15:0] sh_overlap_floor;

  verdict_t    pending_verdicts[$];
  int          mismatches;
  longint      cycles;
  int          n_items, n_results, n_overlap, n_window, n_drop, n_ovf;
  int          burst_left;
  bit          steady;

  iou_box_class_matcher_unit uut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // a*b > c*d, exact
  function automatic bit prod_gt(longint unsigned a, longint unsigned b,
                                 longint unsigned c, longint unsigned d);
    logic [127:0] p1, p2;
    p1 = 128'(a) * 128'(b);
    p2 = 128'(c) * 128'(d);
    return p1 > p2;
  endfunction

  // store one detector box if it clears the area floor
  function automatic void store_box(int cx, int cy, int w, int h, logic [1:0] c);
    int ww, x1, y1;
    longint unsigned area;
    area = longint'(w) * longint'(h);
    if (!(area > longint'(sh_area_floor) * 256)) return;
    if (sh_count >= TBL_DEPTH) begin
      sh_ovf = 1'b1;
      return;
    end
    ww = (w * 12 + 5) / 10;
    x1 = cx - ww / 2;
    y1 = cy - h / 2;
    sh_x1[sh_count] = clamp16(x1);
    sh_x2[sh_count] = clamp16(x1 + ww);
    sh_y1[sh_count] = clamp16(y1);
    sh_y2[sh_count] = clamp16(y1 + h);
    sh_cls[sh_count] = (c == 2'd3) ? 2'd0 : c;
    sh_count++;
  endfunction

  // classify a cluster box against the table
  function automatic verdict_t classify(int ql, int qr, int qt, int qb, int gx, int gy);
    verdict_t v;
    longint qarea, inter, sarea, uni;
    longint unsigned best_i, best_u;
    logic [1:0] best_cls;
    bit found, near_x;
    int xl, xr, yt, yb;
    qarea = longint'(qr - ql) * longint'(qb - qt);
    best_i = 0;
    best_u = 1;
    best_cls = 2'd0;
    found = 0;
    for (int j = 0; j < sh_count; j++) begin
      xl = (ql > sh_x1[j]) ? ql : sh_x1[j];
      xr = (qr < sh_x2[j]) ? qr : sh_x2[j];
      yt = (qt > sh_y1[j]) ? qt : sh_y1[j];
      yb = (qb < sh_y2[j]) ? qb : sh_y2[j];
      if (xr <= xl || yb <= yt) continue;
      inter = longint'(xr - xl) * longint'(yb - yt);
      sarea = longint'(sh_x2[j] - sh_x1[j]) * longint'(sh_y2[j] - sh_y1[j]);
      uni = qarea + sarea - inter;
      if (uni <= 0) continue;
      if (prod_gt(inter, best_u, best_i, uni)) begin
        best_i = inter;
        best_u = uni;
        best_cls = sh_cls[j];
        found = 1;
      end
    end
    near_x = (5 * gx > -512) && (5 * gx < 512);
    if (found && prod_gt(best_i, 65536, longint'(sh_overlap_floor), best_u)) begin
      v.kept = 1'b1; v.how = HOW_OVERLAP; v.cls = best_cls;
    end else if (near_x && gy > -256 && 5 * gy < -512) begin
      v.kept = 1'b1; v.how = HOW_WINDOW; v.cls = 2'd1;
    end else if (near_x && gy < 256 && 5 * gy > 512) begin
      v.kept = 1'b1; v.how = HOW_WINDOW; v.cls = 2'd2;
    end else begin
      v.kept = 1'b0; v.how = HOW_DROP; v.cls = 2'd0;
    end
    v.gx = gx[15:0];
    v.gy = gy[15:0];
    v.ovf = sh_ovf;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
  endtask

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    verdict_t w;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_x), 32'd0);
      end else begin
        w = pending_verdicts.pop_front();
        if (out_kept !== w.kept) report_mismatch("kept", 32'(out_kept), 32'(w.kept));
        if (out_how !== w.how) report_mismatch("how", 32'(out_how), 32'(w.how));
        if (out_class_out !== w.cls) report_mismatch("class", 32'(out_class_out), 32'(w.cls));
        if (out_x !== w.gx) report_mismatch("out_x", 32'(out_x), 32'(w.gx));
        if (out_y !== w.gy) report_mismatch("out_y", 32'(out_y), 32'(w.gy));
        if (out_table_overflow !== w.ovf)
          report_mismatch("overflow", 32'(out_table_overflow), 32'(w.ovf));
        case (w.how)
          HOW_OVERLAP: n_overlap++;
          HOW_WINDOW: n_window++;
          default: n_drop++;
        endcase
        if (w.ovf) n_ovf++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL iou_box_class_matcher_unit");
      $finish;
    end
  end

  // send one word; called at a falling edge, returns at a falling edge
  task automatic send_word(logic [1:0] f, int cx, int cy, int w, int h, logic [1:0] c,
                           int l, int r, int t, int b, int gx, int gy);
    in_func = f;
    in_det_center_x = cx[15:0];
    in_det_center_y = cy[15:0];
    in_det_width = w[14:0];
    in_det_height = h[14:0];
    in_det_class = c;
    in_box_left = l[15:0];
    in_box_right = r[15:0];
    in_box_top = t[15:0];
    in_box_bottom = b[15:0];
    in_ground_x = gx[15:0];
    in_ground_y = gy[15:0];
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    n_items++;
    case (f)
      FUNC_CLEAR: begin
        sh_count = 0;
        sh_ovf = 1'b0;
      end
      FUNC_LOAD: store_box(cx, cy, w, h, c);
      FUNC_QUERY: pending_verdicts.insert(pending_verdicts.size(),
                                          classify(l, r, t, b, gx, gy));
      default: ;
    endcase
    @(negedge clk);
    if (!steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        start = 1'b0;
        repeat ($urandom_range(12, 1)) @(negedge clk);
        burst_left = $urandom_range(10, 1);
      end
    end
  endtask

  function automatic int rnd16();
    return $signed(16'($urandom));
  endfunction

  task automatic load_box(int cx, int cy, int w, int h, logic [1:0] c);
    send_word(FUNC_LOAD, cx, cy, w, h, c, rnd16(), rnd16(), rnd16(), rnd16(),
              rnd16(), rnd16());
  endtask

  task automatic query_box(int l, int r, int t, int b, int gx, int gy);
    send_word(FUNC_QUERY, rnd16(), rnd16(), $urandom_range(32767), $urandom_range(32767),
              2'($urandom), l, r, t, b, gx, gy);
  endtask

  task automatic clear_table();
    send_word(FUNC_CLEAR, rnd16(), rnd16(), $urandom_range(32767), $urandom_range(32767),
              2'($urandom), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  // hold off until every prediction has been met
  task automatic drain();
    start = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  // write one register with the block idle
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == CFG_AREA_FLOOR) sh_area_floor = val;
    else sh_overlap_floor = val[15:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // field extremes, saturation, unknown class and func, near windows
  task automatic test_directed();
    write_reg(CFG_AREA_FLOOR, 24'd0);
    write_reg(CFG_OVERLAP_FLOOR, 16'd0);
    clear_table();
    load_box(32767, 32767, 32767, 32767, 2'd2);
    load_box(-32768, -32768, 32767, 32767, 2'd1);
    load_box(0, 0, 0, 0, 2'd0);
    load_box(100, 100, 1, 1, 2'd3);
    load_box(0, 0, 800, 600, 2'd1);
    query_box(-480, 480, -300, 300, 0, 0);
    query_box(32767, -32768, 32767, -32768, -32768, 32767);
    query_box(-32768, 32767, -32768, 32767, 32767, -32768);
    query_box(100, 101, 100, 101, 0, 0);
    send_word(2'd3, 0, 0, 1000, 1000, 2'd1, 0, 0, 0, 0, 0, 0);
    clear_table();
    // near windows and their edges
    query_box(0, 0, 0, 0, 0, -150);
    query_box(0, 0, 0, 0, 0, 150);
    query_box(0, 0, 0, 0, 102, -103);
    query_box(0, 0, 0, 0, -102, 103);
    query_box(0, 0, 0, 0, 103, -150);
    query_box(0, 0, 0, 0, 0, -255);
    query_box(0, 0, 0, 0, 0, 255);
    query_box(0, 0, 0, 0, 0, -256);
    query_box(0, 0, 0, 0, 0, 256);
    query_box(0, 0, 0, 0, 0, 102);
    write_reg(CFG_OVERLAP_FLOOR, 16'hFFFF);
    load_box(0, 0, 1000, 1000, 2'd2);
    query_box(-600, 600, -500, 500, 0, 0);
    query_box(-600, 600, -500, 500, 0, -150);
  endtask

  // fill past the table depth, then clear
  task automatic test_overflow();
    write_reg(CFG_AREA_FLOOR, AREA_FLOOR_RST);
    write_reg(CFG_OVERLAP_FLOOR, OVERLAP_FLOOR_RST);
    clear_table();
    for (int i = 0; i < TBL_DEPTH + 3; i++)
      load_box(i * 900 - 16000, i * 300, 400 + i, 300 + i, 2'(i));
    query_box(-16500, -15500, -200, 200, 0, 0);
    query_box(13000, 14000, 9700, 10200, 0, 150);
    clear_table();
    query_box(-16500, -15500, -200, 200, 0, 0);
  endtask

  // one phase of table scenes with queries aimed at stored boxes plus noise
  task automatic random_phase(int n);
    int done, nbox, j, jit;
    done = 0;
    while (done < n) begin
      if ($urandom_range(9) == 0) begin
        // noise: fully random word
        send_word(2'($urandom), rnd16(), rnd16(), $urandom_range(32767),
                  $urandom_range(32767), 2'($urandom), rnd16(), rnd16(), rnd16(),
                  rnd16(), rnd16(), rnd16());
        done++;
        continue;
      end
      clear_table();
      nbox = $urandom_range(8, 1);
      if ($urandom_range(15) == 0) nbox = TBL_DEPTH + $urandom_range(3);
      for (int k = 0; k < nbox; k++)
        load_box($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                 $urandom_range(4000, 100), $urandom_range(4000, 100), 2'($urandom));
      done += nbox + 1;
      repeat ($urandom_range(6, 1)) begin
        if (sh_count > 0 && $urandom_range(3) != 0) begin
          j = $urandom_range(sh_count - 1);
          jit = $urandom_range(600);
          query_box(sh_x1[j] + $urandom_range(2 * jit) - jit,
                    sh_x2[j] + $urandom_range(2 * jit) - jit,
                    sh_y1[j] + $urandom_range(2 * jit) - jit,
                    sh_y2[j] + $urandom_range(2 * jit) - jit,
                    $urandom_range(300) - 150, $urandom_range(600) - 300);
        end else if ($urandom_range(1)) begin
          query_box(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        end else begin
          query_box($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                    $urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                    $urandom_range(300) - 150, $urandom_range(600) - 300);
        end
        done++;
      end
    end
  endtask

  // random scenes under several register settings
  task automatic test_random();
    write_reg(CFG_AREA_FLOOR, AREA_FLOOR_RST);
    write_reg(CFG_OVERLAP_FLOOR, OVERLAP_FLOOR_RST);
    random_phase(300);
    drain();
    steady = 1;
    random_phase(150);
    steady = 0;
    write_reg(CFG_AREA_FLOOR, 24'd0);
    write_reg(CFG_OVERLAP_FLOOR, 16'd0);
    random_phase(250);
    write_reg(CFG_AREA_FLOOR, 24'hFFFFFF);
    write_reg(CFG_OVERLAP_FLOOR, 16'hFFFF);
    random_phase(100);
    write_reg(CFG_AREA_FLOOR, 24'($urandom_range(20000)));
    write_reg(CFG_OVERLAP_FLOOR, 16'($urandom));
    random_phase(250);
    write_reg(CFG_AREA_FLOOR, 24'd5000);
    write_reg(CFG_OVERLAP_FLOOR, 16'd40000);
    random_phase(250);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_CLEAR;
    in_det_center_x = '0;
    in_det_center_y = '0;
    in_det_width = '0;
    in_det_height = '0;
    in_det_class = '0;
    in_box_left = '0;
    in_box_right = '0;
    in_box_top = '0;
    in_box_bottom = '0;
    in_ground_x = '0;
    in_ground_y = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_AREA_FLOOR;
    cfg_data = '0;
    sh_count = 0;
    sh_ovf = 1'b0;
    sh_area_floor = AREA_FLOOR_RST;
    sh_overlap_floor = OVERLAP_FLOOR_RST;
    mismatches = 0;
    cycles = 0;
    n_items = 0;
    n_results = 0;
    n_overlap = 0;
    n_window = 0;
    n_drop = 0;
    n_ovf = 0;
    burst_left = 4;
    steady = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_overflow();
    test_random();

    drain();
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d words, %0d results: %0d overlap, %0d window, %0d dropped",
             n_items, n_results, n_overlap, n_window, n_drop);
    $display("results with table overflow set: %0d, mismatches: %0d", n_ovf, mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("PASS iou_box_class_matcher_unit");
    end else begin
      $display("FAIL iou_box_class_matcher_unit");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ibcm_pkg.sv
hdl/ibcm_cell.sv
hdl/ibcm_mul2.sv
hdl/iou_box_class_matcher_unit.sv
verif/iou_box_class_matcher_unit_tb.sv
